[sv/aabb_pair_contact_tracker_macros.svh]
// Assertion macros for the AABB pair contact tracker.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef AABB_PAIR_CONTACT_TRACKER_MACROS_SVH
`define AABB_PAIR_CONTACT_TRACKER_MACROS_SVH
`ifndef SYNTHESIS
// check that prop holds at every clock edge outside reset
`define APCT_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// check that cond is never true outside reset
`define APCT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define APCT_ASSERT(label, clk, rst_n, prop, msg)
`define APCT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

[sv/apct_pkg.sv]
// Shared constants for the AABB pair contact tracker.
// Used by the top level; no dependencies.
package apct_pkg;

	// default parameter values
	localparam int NUM_IDS_DEF    = 64;
	localparam int COORD_BITS_DEF = 16;

	// fixed field widths
	localparam int ID_BITS    = 6;
	localparam int EVENT_BITS = 2;

	// contact event codes
	localparam logic [EVENT_BITS-1:0] EV_NONE  = 2'd0;
	localparam logic [EVENT_BITS-1:0] EV_BEGIN = 2'd1;
	localparam logic [EVENT_BITS-1:0] EV_STAY  = 2'd2;
	localparam logic [EVENT_BITS-1:0] EV_END   = 2'd3;

endpackage

[sv/apct_ram.sv]
// Generic simple dual-port RAM with registered read.
// One write port, one read port with read enable; no dependencies.
module apct_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[sv/aabb_pair_contact_tracker.sv]
// AABB pair contact tracker top level: overlap test, contact bit table, event output.
// Depends on apct_pkg, apct_ram and aabb_pair_contact_tracker_macros.svh.
//
//  channel  | dir | beat contents (tdata, lowest bits first)
//  ---------+-----+----------------------------------------------------------------
//  s_axis   | in  | left_id, right_id, left_cx, left_cy, left_w, left_h,
//           |     | right_cx, right_cy, right_w, right_h, either_dead, zero pad
//  m_axis   | out | contact_event, boxes_overlap, zero pad
//
// One pair per cycle sustained while the output is not stalled and no clearing pass runs.
// A beat accepted into s1 is tested there (contact bit read from the RAM, overlap compare)
// and lands in the output register when s1 advances. The contact table is one bit per
// ordered ID pair in a RAM; a pair following at once on the same ID pair takes its bit by
// forwarding. After reset a clearing pass zeroes NUM_IDS*NUM_IDS bits (4096 by default);
// s_axis_tready stays low during it. A stalled output holds s1, and s1 holds input.
`include "aabb_pair_contact_tracker_macros.svh"

module aabb_pair_contact_tracker
	import apct_pkg::*;
#(
	parameter int NUM_IDS    = NUM_IDS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF,
	localparam int IN_BITS   = 2*ID_BITS + 8*COORD_BITS + 1,
	localparam int IN_TDATA  = ((IN_BITS + 7) / 8) * 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// left_id, right_id, left_cx, left_cy, left_w, left_h,
	// right_cx, right_cy, right_w, right_h, either_dead
	input  logic [IN_TDATA-1:0] s_axis_tdata,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// contact_event[1:0], boxes_overlap[2]
	output logic [7:0]          m_axis_tdata
);

	localparam int DEPTH = NUM_IDS * NUM_IDS;
	localparam int AW    = $clog2(DEPTH);
	localparam int CB    = COORD_BITS;

	// field offsets in s_axis_tdata
	localparam int OFF_LID  = 0;
	localparam int OFF_RID  = ID_BITS;
	localparam int OFF_LCX  = 2*ID_BITS;
	localparam int OFF_LCY  = OFF_LCX + CB;
	localparam int OFF_LW   = OFF_LCY + CB;
	localparam int OFF_LH   = OFF_LW + CB;
	localparam int OFF_RCX  = OFF_LH + CB;
	localparam int OFF_RCY  = OFF_RCX + CB;
	localparam int OFF_RW   = OFF_RCY + CB;
	localparam int OFF_RH   = OFF_RW + CB;
	localparam int OFF_DEAD = OFF_RH + CB;

	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

	// input field views
	logic [ID_BITS-1:0] in_lid, in_rid;
	logic               in_hit;
	logic [AW-1:0]      in_addr;

	// clearing pass
	logic          clr_busy_q;
	logic [AW-1:0] clr_addr_q;

	// s1 stage
	logic                 valid_s1;
	logic                 hit_s1;
	logic [AW-1:0]        addr_s1;
	logic signed [CB-1:0] lcx_s1, lcy_s1, rcx_s1, rcy_s1;
	logic [CB-1:0]        lw_s1, lh_s1, rw_s1, rh_s1;
	logic                 dead_s1;
	logic                 fwd_s1;
	logic                 fwd_bit_s1;

	// output register
	logic                  out_valid_q;
	logic [EVENT_BITS-1:0] out_event_q;
	logic                  out_overlap_q;

	// handshake and datapath
	logic                  accept;
	logic                  adv_s1;
	logic                  rd_bit;
	logic                  had;
	logic                  new_bit;
	logic                  ov_x, ov_y, ov;
	logic [EVENT_BITS-1:0] ev;
	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic                  ram_wdata;

	// decode ids of the incoming beat
	assign in_lid  = s_axis_tdata[OFF_LID +: ID_BITS];
	assign in_rid  = s_axis_tdata[OFF_RID +: ID_BITS];
	assign in_hit  = (in_lid != in_rid) && (32'(in_lid) < NUM_IDS) && (32'(in_rid) < NUM_IDS);
	assign in_addr = AW'(32'(in_lid) * NUM_IDS + 32'(in_rid));

	// stage flow
	assign adv_s1        = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !clr_busy_q && (!valid_s1 || adv_s1);
	assign accept        = s_axis_tvalid && s_axis_tready;

	// overlap per axis: 2*|dc| <= wl + wr
	function automatic logic axis_ov(
		input logic signed [CB-1:0] lc,
		input logic signed [CB-1:0] rc,
		input logic [CB-1:0]        ls,
		input logic [CB-1:0]        rs
	);
		logic signed [CB:0] d;
		logic [CB:0]        mag;
		logic [CB+1:0]      twice;
		logic [CB+1:0]      span;
		d     = (CB+1)'(lc) - (CB+1)'(rc);
		mag   = d[CB] ? (CB+1)'(-d) : (CB+1)'(d);
		twice = {mag, 1'b0};
		span  = (CB+2)'(ls) + (CB+2)'(rs);
		return !(twice > span);
	endfunction

	assign ov_x = axis_ov(lcx_s1, rcx_s1, lw_s1, rw_s1);
	assign ov_y = axis_ov(lcy_s1, rcy_s1, lh_s1, rh_s1);
	assign ov   = ov_x && ov_y;

	// stored contact bit, forwarded from the previous beat on the same pair
	assign had     = fwd_s1 ? fwd_bit_s1 : rd_bit;
	assign new_bit = ov && !dead_s1;

	// event decision
	always_comb begin
		ev = EV_NONE;
		if (hit_s1) begin
			case ({ov, had})
				2'b11:   ev = dead_s1 ? EV_END : EV_STAY;
				2'b10:   ev = dead_s1 ? EV_NONE : EV_BEGIN;
				2'b01:   ev = EV_END;
				default: ev = EV_NONE;
			endcase
		end
	end

	// table write: clearing pass first, then updates from s1
	assign ram_we    = clr_busy_q || (adv_s1 && hit_s1);
	assign ram_waddr = clr_busy_q ? clr_addr_q : addr_s1;
	assign ram_wdata = clr_busy_q ? 1'b0 : new_bit;

	apct_ram #(
		.WIDTH(1),
		.DEPTH(DEPTH)
	) u_contact_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (accept),
		.raddr(in_addr),
		.rdata(rd_bit)
	);

	// sweep the table to zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == LAST_ADDR) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// s1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// s1 payload and forwarding flag
	always_ff @(posedge clk) begin
		if (accept) begin
			hit_s1     <= in_hit;
			addr_s1    <= in_addr;
			lcx_s1     <= s_axis_tdata[OFF_LCX +: CB];
			lcy_s1     <= s_axis_tdata[OFF_LCY +: CB];
			lw_s1      <= s_axis_tdata[OFF_LW +: CB];
			lh_s1      <= s_axis_tdata[OFF_LH +: CB];
			rcx_s1     <= s_axis_tdata[OFF_RCX +: CB];
			rcy_s1     <= s_axis_tdata[OFF_RCY +: CB];
			rw_s1      <= s_axis_tdata[OFF_RW +: CB];
			rh_s1      <= s_axis_tdata[OFF_RH +: CB];
			dead_s1    <= s_axis_tdata[OFF_DEAD];
			fwd_s1     <= adv_s1 && hit_s1 && in_hit && (addr_s1 == in_addr);
			fwd_bit_s1 <= new_bit;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_event_q   <= ev;
			out_overlap_q <= ov;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'b0, out_overlap_q, out_event_q};

	// checks
	`APCT_NEVER(a_no_out_in_clear, clk, arst_n, clr_busy_q && (valid_s1 || m_axis_tvalid),
		"pipeline busy during table clear")
	`APCT_ASSERT(a_miss_gives_none, clk, arst_n, adv_s1 && !hit_s1 |=> m_axis_tdata[1:0] == EV_NONE,
		"event on equal or out-of-range ids")
	`APCT_NEVER(a_begin_stay_need_ov, clk, arst_n,
		m_axis_tvalid && (out_event_q == EV_BEGIN || out_event_q == EV_STAY) && !out_overlap_q,
		"begin or stay without overlap")

endmodule
